// ----- design/tcw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer package
// Dimensions, command codes, payload types and the control and status
// structures that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLS       = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CNT_W      = $clog2(CELL_COUNT + 1);
   localparam int LINE_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W      = (COLS > 1) ? $clog2(COLS) : 1;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE   = 8'h20;
   localparam logic [7:0] ATTR_RESET   = 8'h0F;

   localparam logic [1:0] CMD_PUT_CHAR   = 2'd0;
   localparam logic [1:0] CMD_PLACE_CHAR = 2'd1;
   localparam logic [1:0] CMD_CLEAR      = 2'd2;
   localparam logic [1:0] CMD_READ_CELL  = 2'd3;

   // Memory port usage.
   localparam logic [2:0] MEM_NONE      = 3'd0;
   localparam logic [2:0] MEM_REQ       = 3'd1;
   localparam logic [2:0] MEM_FILL_INIT = 3'd2;
   localparam logic [2:0] MEM_FILL_ATTR = 3'd3;
   localparam logic [2:0] MEM_COPY      = 3'd4;

   // Sweep counter operations.
   localparam logic [2:0] CNT_HOLD        = 3'd0;
   localparam logic [2:0] CNT_INC         = 3'd1;
   localparam logic [2:0] CNT_ZERO        = 3'd2;
   localparam logic [2:0] CNT_COPY_START  = 3'd3;
   localparam logic [2:0] CNT_BLANK_START = 3'd4;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] char_code;
      logic [7:0] row_pos;
      logic [7:0] col_pos;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [15:0] cell_value;
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
   } rsp_type;

   typedef struct packed {
      logic       accept;
      logic       load_imm;
      logic       load_late;
      logic [2:0] mem_op;
      logic [2:0] cnt_op;
   } ctrl_type;

   typedef struct packed {
      logic scroll;
      logic last_cell;
      logic copy_end;
      logic rsp_free;
   } status_type;

endpackage
`default_nettype wire

// ----- design/tcw_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- design/tcw_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences the reset fill, clear, scroll and read commands and issues
// memory, counter and response commands to the datapath.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_cmd,
   input  wire status_type status,
   output ctrl_type        ctrl
);

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CLEAR = 3'd2;
   localparam logic [2:0] ST_COPY  = 3'd3;
   localparam logic [2:0] ST_BLANK = 3'd4;
   localparam logic [2:0] ST_READ  = 3'd5;
   localparam logic [2:0] ST_RESP  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      ctrl           = '0;
      ctrl.mem_op    = MEM_NONE;
      ctrl.cnt_op    = CNT_HOLD;
      case (state_ff)
         ST_INIT: begin
            ctrl.mem_op = MEM_FILL_INIT;
            ctrl.cnt_op = CNT_INC;
            if (status.last_cell) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = status.rsp_free;
            if (req_valid && status.rsp_free) begin
               ctrl.accept = 1'b1;
               ctrl.mem_op = MEM_REQ;
               case (req_cmd)
                  CMD_PUT_CHAR: begin
                     if (status.scroll) begin
                        ctrl.cnt_op = CNT_COPY_START;
                        state_in    = ST_COPY;
                     end else begin
                        ctrl.load_imm = 1'b1;
                     end
                  end
                  CMD_PLACE_CHAR: begin
                     ctrl.load_imm = 1'b1;
                  end
                  CMD_CLEAR: begin
                     ctrl.cnt_op = CNT_ZERO;
                     state_in    = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_READ;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            ctrl.mem_op = MEM_FILL_ATTR;
            ctrl.cnt_op = CNT_INC;
            if (status.last_cell) begin
               state_in = ST_RESP;
            end
         end
         ST_COPY: begin
            ctrl.mem_op = MEM_COPY;
            if (status.copy_end) begin
               ctrl.cnt_op = CNT_BLANK_START;
               state_in    = ST_BLANK;
            end else begin
               ctrl.cnt_op = CNT_INC;
            end
         end
         ST_BLANK: begin
            ctrl.mem_op = MEM_FILL_ATTR;
            ctrl.cnt_op = CNT_INC;
            if (status.last_cell) begin
               state_in = ST_RESP;
            end
         end
         ST_READ: begin
            // The response register was emptied when the read was accepted.
            ctrl.load_late = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               ctrl.load_late = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- design/tcw_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer datapath
// Cell store, cursor, attribute register, sweep counter and the response
// output register.
// ----------------------------------------------------------------------------
module tcw_datapath import tcw_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire ctrl_type   ctrl,
   output status_type      status,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data,
   input  wire logic       csr_write,
   input  wire logic [7:0] csr_data
);

   logic [7:0]        attribute_ff;
   logic [LINE_W-1:0] line_ff;
   logic [LINE_W-1:0] line_in;
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic              ok_ff;
   logic              is_read_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_data_ff;
   rsp_type           rsp_data_in;

   logic              in_range;
   logic              newline;
   logic              wrap;
   logic [CNT_W-1:0]  cur_idx;
   logic [CNT_W-1:0]  req_idx;
   logic [CNT_W-1:0]  copy_wr_idx;
   logic [LINE_W-1:0] put_line;
   logic [COL_W-1:0]  put_col;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [15:0]       wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [15:0]       rd_data;

   assign in_range = (32'(req_data.row_pos) < ROWS) && (32'(req_data.col_pos) < COLS);
   assign newline  = (req_data.char_code == NEWLINE_CODE);
   assign wrap     = (32'(col_ff) == COLS - 1);
   assign cur_idx  = CNT_W'(line_ff) * CNT_W'(COLS) + CNT_W'(col_ff);
   assign req_idx  = CNT_W'(req_data.row_pos) * CNT_W'(COLS) + CNT_W'(req_data.col_pos);
   assign copy_wr_idx = cnt_ff - CNT_W'(COLS + 1);

   // Cursor after a put_char: newline or wrap goes to the next line, which
   // stays on the last line when the store scrolls.
   always_comb begin
      put_line = line_ff;
      put_col  = col_ff + COL_W'(1);
      if (newline || wrap) begin
         put_col = '0;
         if (32'(line_ff) != ROWS - 1) begin
            put_line = line_ff + LINE_W'(1);
         end
      end
   end

   always_comb begin
      status.scroll    = (req_data.cmd == CMD_PUT_CHAR) && (32'(line_ff) == ROWS - 1)
                         && (newline || wrap);
      status.last_cell = (cnt_ff == CNT_W'(CELL_COUNT - 1));
      status.copy_end  = (cnt_ff == CNT_W'(CELL_COUNT));
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      line_in = line_ff;
      col_in  = col_ff;
      if (ctrl.accept) begin
         if (req_data.cmd == CMD_PUT_CHAR) begin
            line_in = put_line;
            col_in  = put_col;
         end else if (req_data.cmd == CMD_CLEAR) begin
            line_in = '0;
            col_in  = '0;
         end
      end
   end

   always_comb begin
      case (ctrl.cnt_op)
         CNT_INC:         cnt_in = cnt_ff + CNT_W'(1);
         CNT_ZERO:        cnt_in = '0;
         CNT_COPY_START:  cnt_in = CNT_W'(COLS);
         CNT_BLANK_START: cnt_in = CNT_W'(CELL_COUNT - COLS);
         default:         cnt_in = cnt_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff[ADDR_W-1:0];
      wr_data = {attribute_ff, SPACE_CODE};
      rd_en   = 1'b0;
      rd_addr = cnt_ff[ADDR_W-1:0];
      case (ctrl.mem_op)
         MEM_REQ: begin
            wr_data = {attribute_ff, req_data.char_code};
            rd_addr = req_idx[ADDR_W-1:0];
            if (req_data.cmd == CMD_PUT_CHAR) begin
               wr_en   = !newline;
               wr_addr = cur_idx[ADDR_W-1:0];
            end else if (req_data.cmd == CMD_PLACE_CHAR) begin
               wr_en   = in_range;
               wr_addr = req_idx[ADDR_W-1:0];
            end else if (req_data.cmd == CMD_READ_CELL) begin
               rd_en = in_range;
            end
         end
         MEM_FILL_INIT: begin
            wr_en   = 1'b1;
            wr_data = {ATTR_RESET, SPACE_CODE};
         end
         MEM_FILL_ATTR: begin
            wr_en = 1'b1;
         end
         MEM_COPY: begin
            // Read one row ahead; the data lands in the next cycle and is
            // written one row up.
            rd_en   = (cnt_ff != CNT_W'(CELL_COUNT));
            wr_en   = (cnt_ff > CNT_W'(COLS));
            wr_addr = copy_wr_idx[ADDR_W-1:0];
            wr_data = rd_data;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (CELL_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_data_in            = rsp_data_ff;
      rsp_data_in.cursor_row = 5'(line_in);
      rsp_data_in.cursor_col = 7'(col_in);
      if (ctrl.load_imm) begin
         rsp_data_in.ok         = (req_data.cmd == CMD_PUT_CHAR) || in_range;
         rsp_data_in.cell_value = '0;
      end else begin
         rsp_data_in.ok         = ok_ff;
         rsp_data_in.cell_value = (is_read_ff && ok_ff) ? rd_data : 16'd0;
      end
   end

   always_comb begin
      if (ctrl.load_imm || ctrl.load_late) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attribute_ff <= ATTR_RESET;
         line_ff      <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            attribute_ff <= csr_data;
         end
         line_ff      <= line_in;
         col_ff       <= col_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         ok_ff      <= (req_data.cmd != CMD_READ_CELL) || in_range;
         is_read_ff <= (req_data.cmd == CMD_READ_CELL);
      end
      if (ctrl.load_imm || ctrl.load_late) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ----- design/text_console_writer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer
// Character cell console engine with a ROWS x COLS cell store, a cursor,
// line wrap, scrolling, clear and cell read-back.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                          Direction  Moves
//   req      req_valid/req_ready/req_data   in         one command item
//   rsp      rsp_valid/rsp_ready/rsp_data   out        one result item
//   csr      csr_valid/csr_ready/csr_data   in         attribute byte
//
// A put_char that does not scroll and a place_char are answered straight from
// the request; every read_cell goes through the registered store read, in
// range or not. A clear and a scrolling put_char both walk the store. After
// reset a fill pass blanks the store with req_ready low; attribute writes are
// taken throughout. A stalled result holds req_ready low; a new item may
// enter in the cycle the result is taken.
//
module text_console_writer import tcw_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_data
);

   ctrl_type   ctrl;
   status_type status;

   // The attribute register can always take a write; software must only write
   // it while the console is idle, and the block itself does not enforce this.
   assign csr_ready = 1'b1;

   // The controller sequences the long operations; the datapath holds all
   // storage and the response register.
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_data.cmd),
      .status    (status),
      .ctrl      (ctrl)
   );

   tcw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data)
   );

   // A pending result is never overwritten by a new one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !(ctrl.load_imm || ctrl.load_late))
      else $error("result register overwritten while stalled");

   // An accepted read_cell loads its result in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.cmd == CMD_READ_CELL)) |=> ctrl.load_late)
      else $error("read_cell result not loaded one cycle after accept");

   // Items are only accepted when the result register is free.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.accept |-> (status.rsp_free && ctrl.mem_op == MEM_REQ))
      else $error("item accepted with result register busy");

   // Only one result source is chosen in a cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(ctrl.load_imm && ctrl.load_late))
      else $error("two result sources in one cycle");

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives command items with random gaps, stalls the result channel at random
// and predicts every result from a private copy of the cell store, cursor and
// attribute, comparing each result field by field in order of acceptance.
// ----------------------------------------------------------------------------
module tb_top import tcw_pkg::*; ();

   // Scoreboard: keeps its own console state and a queue of predicted results.
   class console_scoreboard;
      logic [15:0] cells [CELL_COUNT];
      int unsigned cur_row;
      int unsigned cur_col;
      logic [7:0]  attr;
      rsp_type     predicted_q[$];
      int          errors;

      function new();
         attr   = ATTR_RESET;
         errors = 0;
         blank_store();
      endfunction

      function void set_attribute(input logic [7:0] value);
         attr = value;
      endfunction

      function int pending();
         return predicted_q.size();
      endfunction

      // Clear blanks with the attribute in force now and homes the cursor.
      function void blank_store();
         foreach (cells[i]) cells[i] = {attr, SPACE_CODE};
         cur_row = 0;
         cur_col = 0;
      endfunction

      // Moving below the last row shifts every row up and blanks the bottom.
      function void next_row();
         cur_col = 0;
         cur_row++;
         if (cur_row >= ROWS) begin
            for (int i = 0; i + COLS < CELL_COUNT; i++) cells[i] = cells[i + COLS];
            for (int i = CELL_COUNT - COLS; i < CELL_COUNT; i++) begin
               cells[i] = {attr, SPACE_CODE};
            end
            cur_row = ROWS - 1;
         end
      endfunction

      // Called once per accepted command item, in order of acceptance.
      function void note_command(input req_type c);
         rsp_type r;
         bit      in_range;
         in_range     = (c.row_pos < ROWS) && (c.col_pos < COLS);
         r.ok         = 1'b1;
         r.cell_value = '0;
         case (c.cmd)
            CMD_PUT_CHAR: begin
               if (c.char_code == NEWLINE_CODE) begin
                  next_row();
               end else begin
                  cells[cur_row * COLS + cur_col] = {attr, c.char_code};
                  cur_col++;
                  if (cur_col >= COLS) next_row();
               end
            end
            CMD_PLACE_CHAR: begin
               if (in_range) cells[c.row_pos * COLS + c.col_pos] = {attr, c.char_code};
               else r.ok = 1'b0;
            end
            CMD_CLEAR: begin
               blank_store();
            end
            default: begin
               if (in_range) r.cell_value = cells[c.row_pos * COLS + c.col_pos];
               else r.ok = 1'b0;
            end
         endcase
         r.cursor_row = 5'(cur_row);
         r.cursor_col = 7'(cur_col);
         predicted_q.push_back(r);
      endfunction

      function void check_result(input rsp_type got);
         rsp_type want;
         if (predicted_q.size() == 0) begin
            $error("result item with no command outstanding: %h", got);
            errors++;
            return;
         end
         want = predicted_q.pop_front();
         if (got.ok !== want.ok) begin
            $error("ok mismatch: expected %0d, got %0d", want.ok, got.ok);
            errors++;
         end
         if (got.cell_value !== want.cell_value) begin
            $error("cell_value mismatch: expected %h, got %h",
                   want.cell_value, got.cell_value);
            errors++;
         end
         if (got.cursor_row !== want.cursor_row) begin
            $error("cursor_row mismatch: expected %0d, got %0d",
                   want.cursor_row, got.cursor_row);
            errors++;
         end
         if (got.cursor_col !== want.cursor_col) begin
            $error("cursor_col mismatch: expected %0d, got %0d",
                   want.cursor_col, got.cursor_col);
            errors++;
         end
      endfunction
   endclass

   // The run is stopped here if it hangs. A correct run with every item
   // taking a full clear or scroll, plus the longest gaps and stalls, stays
   // well below this many cycles.
   localparam longint LIMIT_CYCLES = 64'd6_000_000;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [7:0] csr_data;

   // When set, the command side sends back to back with no gaps.
   bit req_quiet = 1'b0;

   console_scoreboard console_sb = new();

   text_console_writer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Half the time no idle at all, most other times a short idle, now and then a long pause.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Results are checked at the edge where they are taken. Values read here
   // are the ones that stood before the edge, so the order of processes in
   // the time step does not matter.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) console_sb.check_result(rsp_data);
   end

   // The result side alternates between ready stretches and stalls. The
   // occasional very long ready stretch gives periods with no stall at all.
   initial begin
      int r;
      rsp_ready <= 1'b0;
      repeat (5) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         r = $urandom_range(0, 99);
         if (r < 70) repeat ($urandom_range(1, 8)) @(posedge clock);
         else if (r < 95) repeat ($urandom_range(9, 40)) @(posedge clock);
         else repeat ($urandom_range(100, 300)) @(posedge clock);
         rsp_ready <= 1'b0;
         repeat (1 + idle_length()) @(posedge clock);
      end
   end

   // Sends one command item. It is entered right after a rising edge and
   // returns at the edge where the item was taken, with req_valid still high
   // so that the next item can follow without a bubble.
   task automatic send_command(input req_type c);
      int gap;
      gap = req_quiet ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      do @(posedge clock); while (!req_ready);
      console_sb.note_command(c);
   endtask

   // Drops req_valid and waits until every predicted result has come back.
   // Every command yields a result, so the block is idle afterwards.
   task automatic finish_batch();
      req_valid <= 1'b0;
      while (console_sb.pending() != 0) @(posedge clock);
   endtask

   // Writes the attribute register. Only called with nothing outstanding.
   task automatic write_attribute(input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      console_sb.set_attribute(value);
   endtask

   // Builds one random command. put_pct and clear_pct set the share of
   // put_char and clear, nl_pct the share of newlines among put_char items.
   // The remainder is split between place_char and read_cell, mostly in range.
   function automatic req_type random_command(input int put_pct, input int nl_pct,
                                              input int clear_pct);
      req_type c;
      int      r;
      c.cmd       = CMD_READ_CELL;
      c.char_code = 8'($urandom_range(0, 255));
      c.row_pos   = 8'($urandom_range(0, 255));
      c.col_pos   = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < put_pct) begin
         c.cmd = CMD_PUT_CHAR;
         if ($urandom_range(0, 99) < nl_pct) c.char_code = NEWLINE_CODE;
      end else if (r < put_pct + clear_pct) begin
         c.cmd = CMD_CLEAR;
      end else begin
         c.cmd = $urandom_range(0, 1) ? CMD_PLACE_CHAR : CMD_READ_CELL;
         if ($urandom_range(0, 3) != 0) begin
            c.row_pos = 8'($urandom_range(0, ROWS - 1));
            c.col_pos = 8'($urandom_range(0, COLS - 1));
         end
      end
      return c;
   endfunction

   // One random phase: the block is drained, the attribute is changed, then
   // a batch of commands with the given mix is sent. Reads of older cells
   // then show that an attribute change only affects later writes.
   task automatic run_phase(input logic [7:0] attr_value, input int count,
                            input int put_pct, input int nl_pct, input int clear_pct);
      finish_batch();
      write_attribute(attr_value);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 39) == 0) req_quiet = !req_quiet;
         send_command(random_command(put_pct, nl_pct, clear_pct));
      end
   endtask

   // Directed opening under the reset attribute: reset contents, corner
   // cells, out-of-range rows and columns, a newline stored by place_char,
   // extreme character codes, a newline by put_char and a clear.
   task automatic run_directed();
      send_command(req_type'{CMD_READ_CELL, 8'h00, 8'd0, 8'd0});
      send_command(req_type'{CMD_READ_CELL, 8'hFF, 8'(ROWS - 1), 8'(COLS - 1)});
      send_command(req_type'{CMD_READ_CELL, 8'h00, 8'(ROWS), 8'd0});
      send_command(req_type'{CMD_READ_CELL, 8'h00, 8'd0, 8'(COLS)});
      send_command(req_type'{CMD_READ_CELL, 8'h00, 8'hFF, 8'hFF});
      send_command(req_type'{CMD_PLACE_CHAR, 8'hFF, 8'd0, 8'd0});
      send_command(req_type'{CMD_PLACE_CHAR, 8'h00, 8'(ROWS - 1), 8'(COLS - 1)});
      send_command(req_type'{CMD_PLACE_CHAR, NEWLINE_CODE, 8'd0, 8'd5});
      send_command(req_type'{CMD_PLACE_CHAR, 8'h41, 8'(ROWS), 8'(COLS - 1)});
      send_command(req_type'{CMD_PLACE_CHAR, 8'h41, 8'd0, 8'(COLS)});
      send_command(req_type'{CMD_READ_CELL, 8'h00, 8'd0, 8'd0});
      send_command(req_type'{CMD_READ_CELL, 8'h00, 8'(ROWS - 1), 8'(COLS - 1)});
      send_command(req_type'{CMD_READ_CELL, 8'h00, 8'd0, 8'd5});
      send_command(req_type'{CMD_PUT_CHAR, 8'h41, 8'hFF, 8'hFF});
      send_command(req_type'{CMD_PUT_CHAR, 8'hFF, 8'h00, 8'h00});
      send_command(req_type'{CMD_PUT_CHAR, 8'h00, 8'hAA, 8'h55});
      send_command(req_type'{CMD_PUT_CHAR, NEWLINE_CODE, 8'h00, 8'h00});
      send_command(req_type'{CMD_PUT_CHAR, 8'h80, 8'h00, 8'h00});
      send_command(req_type'{CMD_READ_CELL, 8'h00, 8'd0, 8'd0});
      send_command(req_type'{CMD_READ_CELL, 8'h00, 8'd1, 8'd0});
      send_command(req_type'{CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF});
      send_command(req_type'{CMD_READ_CELL, 8'h00, 8'd0, 8'd0});
      send_command(req_type'{CMD_READ_CELL, 8'h00, 8'd0, 8'd5});
   endtask

   initial begin
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      reset     <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // The store fill after reset holds req_ready low; the first item
      // simply waits for it.
      run_directed();

      // Mixed traffic, pure text that wraps at the last column, newline
      // heavy traffic that scrolls often, and read heavy traffic.
      run_phase(8'hFF, 100, 50, 10, 2);
      run_phase(8'h00, 150, 90, 1, 0);
      run_phase(8'($urandom_range(0, 255)), 120, 70, 40, 0);
      run_phase(8'($urandom_range(0, 255)), 120, 50, 15, 3);
      run_phase(8'($urandom_range(0, 255)), 110, 30, 20, 1);

      finish_batch();
      // Room for a stray result from a clear or scroll still in the works.
      repeat (CELL_COUNT + 10) @(posedge clock);

      if (console_sb.pending() != 0) begin
         $error("%0d expected results never arrived", console_sb.pending());
      end
      if (console_sb.errors == 0 && console_sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 12);
      $display("timeout after %0d cycles", LIMIT_CYCLES);
      $display("== FAIL ==");
      $finish;
   end

endmodule
`default_nettype wire

// ----- files.f -----
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_ctrl.sv
design/tcw_datapath.sv
design/text_console_writer.sv
tb/sv/tb_top.sv
